[hw/rtl/ict_pkg.sv]
// shared types and constants for the interval claim tracker
`default_nettype none

package ict_pkg;

    // fixed field widths of the stream words
    localparam int FIELD_W   = 32;
    localparam int TDATA_W   = 64;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;

    // command codes carried in the input tuser
    localparam logic CMD_CLAIM = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take_claim;
        logic take_clear;
        logic reply;
        logic prime;
        logic walk;
        logic finish;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic in_empty;
        logic out_free;
        logic walk_end;
        logic finish_done;
    } t_ctl_sts;

endpackage

`default_nettype wire

[hw/rtl/ict_ctrl.sv]
// sequencing state machine for the interval claim tracker
`default_nettype none

module ict_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_cmd,
    output logic                   o_s_tready,
    input  wire ict_pkg::t_ctl_sts i_sts,
    output ict_pkg::t_ctl_cmd      o_cmd
);
    import ict_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_PRIME,
        ST_WALK,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   accept;

    assign accept     = i_s_tvalid && r_ready;
    assign o_s_tready = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_CLEAR) begin
                        o_cmd.take_clear = 1'b1;
                        n_state          = ST_REPLY;
                    end else if (i_sts.in_empty) begin
                        n_state = ST_REPLY;
                    end else begin
                        o_cmd.take_claim = 1'b1;
                        n_state          = i_sts.cnt_zero ? ST_FINISH : ST_PRIME;
                    end
                end
            end
            ST_REPLY: begin
                o_cmd.reply = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_sts.finish_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ict_datapath.sv]
// interval table, walk registers and result register of the claim tracker
`default_nettype none

module ict_datapath #(
    parameter int MAX_INTERVALS = 16,
    parameter int INDEX_BITS    = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ict_pkg::t_ctl_cmd         i_cmd,
    output ict_pkg::t_ctl_sts              o_sts,
    input  wire logic [ict_pkg::FIELD_W-1:0] i_range_begin,
    input  wire logic [ict_pkg::FIELD_W-1:0] i_range_end,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic [ict_pkg::FIELD_W-1:0]    o_piece_begin,
    output logic [ict_pkg::FIELD_W-1:0]    o_piece_end,
    output logic                           o_no_piece,
    output logic                           o_overflow,
    output logic                           o_last
);
    import ict_pkg::*;

    localparam int IW    = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam int CW    = $clog2(MAX_INTERVALS + 1);
    localparam int IDXW  = $clog2(MAX_INTERVALS);
    localparam int MEM_D = 2 ** (IDXW + 1);

    // two banks: the walk reads the live bank and rebuilds into the other
    logic [2*IW-1:0] mem [MEM_D];

    logic [2*IW-1:0] r_rd;
    logic [IW-1:0]   r_b, r_e, r_cur, r_nb, r_ne;
    logic [CW-1:0]   r_j, r_w, r_cnt;
    logic            r_bank, r_merged, r_absorbed, r_emitted;
    logic            r_out_valid, r_none, r_ovf, r_last;
    logic [IW-1:0]   r_pb, r_pe;

    logic [IW-1:0]   in_b, in_e, ent_s, ent_t;
    logic            cls_before, cls_after, active, piece, hold_ins, stall, adv;
    logic            out_free, ovf, fin_piece, fin_emit, fin_done;
    logic            wr_en;
    logic [2*IW-1:0] wr_data;
    logic [IDXW-1:0] rd_idx;
    logic [CW-1:0]   j_inc;

    assign in_b  = i_range_begin[IW-1:0];
    assign in_e  = i_range_end[IW-1:0];
    assign ent_s = r_rd[2*IW-1:IW];
    assign ent_t = r_rd[IW-1:0];
    assign j_inc = r_j + CW'(1);

    assign out_free = !r_out_valid || i_out_ready;

    // classify the entry under the walk
    assign cls_before = ent_t < r_b;
    assign cls_after  = ent_s > r_e;
    assign active     = (ent_s < r_e) && (r_cur < r_e);
    assign piece      = active && (ent_s > r_cur);
    assign hold_ins   = cls_after && !r_merged;
    assign stall      = piece && !out_free;
    assign adv        = i_cmd.walk && !stall && !hold_ins;

    // table full and nothing absorbed: table stays as it was
    assign ovf       = (r_cnt == CW'(MAX_INTERVALS)) && !r_absorbed;
    assign fin_piece = r_cur < r_e;
    assign fin_emit  = fin_piece || !r_emitted;
    assign fin_done  = i_cmd.finish && (!fin_emit || out_free);

    always_comb begin
        wr_en   = 1'b0;
        wr_data = {r_nb, r_ne};
        if (i_cmd.walk && !stall) begin
            if (hold_ins) begin
                wr_en = 1'b1;
            end else if (cls_before || cls_after) begin
                wr_en   = 1'b1;
                wr_data = r_rd;
            end
        end else if (fin_done && !r_merged) begin
            wr_en = 1'b1;
        end
    end

    assign rd_idx = i_cmd.prime ? '0 : (adv ? j_inc[IDXW-1:0] : r_j[IDXW-1:0]);

    always_ff @(posedge i_clk) begin
        if (wr_en && (r_w < CW'(MAX_INTERVALS))) begin
            mem[{~r_bank, r_w[IDXW-1:0]}] <= wr_data;
        end
        r_rd <= mem[{r_bank, rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_clear) begin
                r_cnt <= '0;
            end
            if (fin_done && !ovf) begin
                r_cnt  <= r_w + (r_merged ? CW'(0) : CW'(1));
                r_bank <= ~r_bank;
            end
            if (i_cmd.reply || (adv && piece) || (fin_done && fin_emit)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_claim) begin
            r_b        <= in_b;
            r_e        <= in_e;
            r_cur      <= in_b;
            r_nb       <= in_b;
            r_ne       <= in_e;
            r_w        <= '0;
            r_merged   <= 1'b0;
            r_absorbed <= 1'b0;
            r_emitted  <= 1'b0;
        end
        if (i_cmd.prime) begin
            r_j <= '0;
        end
        if (wr_en) begin
            r_w <= r_w + CW'(1);
            if (hold_ins || i_cmd.finish) begin
                r_merged <= 1'b1;
            end
        end
        if (adv) begin
            r_j <= j_inc;
            if (!cls_before && !cls_after) begin
                r_absorbed <= 1'b1;
                if (ent_s < r_nb) begin
                    r_nb <= ent_s;
                end
                if (ent_t > r_ne) begin
                    r_ne <= ent_t;
                end
            end
            if (active && (ent_t > r_cur)) begin
                r_cur <= ent_t;
            end
            if (piece) begin
                r_emitted <= 1'b1;
            end
        end
        // result payload
        if (i_cmd.reply) begin
            r_pb   <= '0;
            r_pe   <= '0;
            r_none <= 1'b1;
            r_ovf  <= 1'b0;
            r_last <= 1'b1;
        end else if (adv && piece) begin
            r_pb   <= r_cur;
            r_pe   <= ent_s;
            r_none <= 1'b0;
            r_ovf  <= 1'b0;
            r_last <= ent_t >= r_e;
        end else if (fin_done && fin_emit) begin
            r_pb   <= fin_piece ? r_cur : '0;
            r_pe   <= fin_piece ? r_e : '0;
            r_none <= !fin_piece;
            r_ovf  <= ovf;
            r_last <= 1'b1;
        end
    end

    always_comb begin
        o_sts.cnt_zero    = (r_cnt == '0);
        o_sts.in_empty    = !(in_b < in_e);
        o_sts.out_free    = out_free;
        o_sts.walk_end    = adv && (j_inc == r_cnt);
        o_sts.finish_done = fin_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_piece_begin = FIELD_W'(r_pb);
    assign o_piece_end   = FIELD_W'(r_pe);
    assign o_no_piece    = r_none;
    assign o_overflow    = r_ovf;
    assign o_last        = r_last;

endmodule

`default_nettype wire

[hw/rtl/interval_claim_tracker_top.sv]
// top level of the interval claim tracker
//
// channel  dir  word contents (lowest bit first)
// s        in   tdata: range_begin[31:0], range_end[63:32]; tuser: cmd
// m        out  tdata: piece_begin[31:0], piece_end[63:32]; tuser: no_piece, overflow;
//               tlast: last
//
// a claim into a table of n intervals passes through the accept step, a prime read,
// a read of each stored interval and a finish step, plus a step that writes the merged
// interval when it lands ahead of a stored one
// a claim into an empty table skips prime and walk; a clear or empty claim goes to reply
// reset clears the interval count and the output valid; table contents are never cleared
// a held result word stalls reply, walk and finish only on cycles that produce a new word
`default_nettype none

module interval_claim_tracker_top #(
    parameter int MAX_INTERVALS = 16,
    parameter int INDEX_BITS    = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [ict_pkg::TDATA_W-1:0]   i_s_tdata,   // range_begin, range_end
    input  wire logic [ict_pkg::S_TUSER_W-1:0] i_s_tuser,   // cmd
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [ict_pkg::TDATA_W-1:0]        o_m_tdata,   // piece_begin, piece_end
    output logic [ict_pkg::M_TUSER_W-1:0]      o_m_tuser,   // no_piece, overflow
    output logic                               o_m_tlast
);
    import ict_pkg::*;

    t_ctl_cmd          cmd;
    t_ctl_sts          sts;
    logic [FIELD_W-1:0] piece_begin, piece_end;
    logic              no_piece, overflow;

    ict_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ict_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .INDEX_BITS    (INDEX_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_range_begin (i_s_tdata[FIELD_W-1:0]),
        .i_range_end   (i_s_tdata[2*FIELD_W-1:FIELD_W]),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_piece_begin (piece_begin),
        .o_piece_end   (piece_end),
        .o_no_piece    (no_piece),
        .o_overflow    (overflow),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {piece_end, piece_begin};
    assign o_m_tuser = {overflow, no_piece};

endmodule

`default_nettype wire

[hw/rtl/ict_checker.sv]
// port-level checks for the interval claim tracker, bound to the top level
`default_nettype none

module ict_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [ict_pkg::TDATA_W-1:0]   o_m_tdata,
    input wire logic [ict_pkg::M_TUSER_W-1:0] o_m_tuser,
    input wire logic                          o_m_tlast
);
    import ict_pkg::*;

    // a word with no piece carries zero bounds
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("no_piece word with nonzero bounds");

    // a word with no piece always closes its claim
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("no_piece word not marked last");

    // a reported piece is never empty
    a_piece_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |->
            o_m_tdata[FIELD_W-1:0] < o_m_tdata[2*FIELD_W-1:FIELD_W])
        else $error("piece begin not below piece end");

    // a held word keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

endmodule

bind interval_claim_tracker_top ict_checker u_ict_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
